// ===== hdl/prla_pkg.sv =====
// ----------------------------------------------------------------------------
// Page region allocator package
// Shared sizes, codes, datapath commands and the datapath status bundle.
// ----------------------------------------------------------------------------
package prla_pkg;

  localparam int unsigned PW     = 12;
  localparam int unsigned NPAGES = 2 ** PW;
  localparam int unsigned NREG   = 64;
  localparam int unsigned NPEND  = 64;
  localparam int unsigned AW     = $clog2(NREG);
  localparam int unsigned CW     = $clog2(NREG + 1);
  localparam int unsigned PAW    = $clog2(NPEND);
  localparam int unsigned PCW    = $clog2(NPEND + 1);

  typedef logic [PW-1:0] page_t;

  typedef struct packed {
    page_t s;
    page_t l;
  } span_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [5:0] {
    DP_NOP,
    DP_INIT,
    DP_LATCH,
    DP_G_RD,
    DP_FR_PUSH,
    DP_SET_ST1,
    DP_SET_ST2,
    DP_RE_KEEP,
    DP_RE_GROW,
    DP_RD_I,
    DP_RD_IM1,
    DP_RD_I1,
    DP_RD_K1,
    DP_RD_KM1,
    DP_I_INC,
    DP_TK_INIT,
    DP_TK_STEP,
    DP_TK_TAKE,
    DP_GR_TAKE,
    DP_DR_WR,
    DP_DR_END,
    DP_AL_OK,
    DP_AL_FAIL,
    DP_RA_INIT,
    DP_RA_RD,
    DP_RA_LD,
    DP_RA_NEXT,
    DP_RA_KEEP,
    DP_RA_END,
    DP_RS_STEP,
    DP_RS_M1,
    DP_RS_M2,
    DP_INS_INIT,
    DP_INS_WR,
    DP_INS_PUT,
    DP_JN_INIT,
    DP_JN_LDA,
    DP_JN_MRG,
    DP_JN_ADV,
    DP_OUT
  } dp_cmd_e;

  typedef struct packed {
    logic       init;
    logic [1:0] op;
    logic       gp_zero;
    logic       req_zero;
    logic       top;
    logic       pend_full;
    logic       free_full;
    logic       tk_end;
    logic       fit;
    logic       tk_zero;
    logic       keep;
    logic       gr_fit;
    logic       gr_zero;
    logic       dr_more;
    logic       ra_end;
    logic       ra_skip;
    logic       i_end;
    logic       rs_brk;
    logic       c1;
    logic       c2;
    logic       ins_more;
    logic       jn_small;
    logic       jn_end;
    logic       jn_adj;
  } dp_stat_t;

endpackage

// ===== hdl/prla_dp.sv =====
// ----------------------------------------------------------------------------
// Page region allocator datapath
// Region, pending and grant length memories, indexes and result registers.
// ----------------------------------------------------------------------------
module prla_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  prla_pkg::page_t   cfg_wdata_i,
  input  logic [1:0]        op_i,
  input  prla_pkg::page_t   request_pages_i,
  input  logic              from_top_i,
  input  prla_pkg::page_t   grant_page_i,
  input  prla_pkg::dp_cmd_e cmd_i,
  output prla_pkg::dp_stat_t stat_o,
  output prla_pkg::page_t   result_page_o,
  output logic [1:0]        status_o,
  output logic              moved_o
);
  import prla_pkg::*;

  page_t          tot_q;
  logic           init_q;
  logic [CW-1:0]  fcnt_q, i_q, k_q;
  logic [PCW-1:0] pcnt_q, j_q, kept_q;

  logic [1:0] op_q, st_q;
  logic       top_q, mv_q;
  page_t      req_q, gp_q, cur_q, s_q, l_q, res_q, gl_q;
  span_t      a_q, fr_q, pr_q;

  page_t      out_res_q;
  logic [1:0] out_st_q;
  logic       out_mv_q;

  span_t   fmem [NREG];
  span_t   pmem [NPEND];
  page_t   gmem [NPAGES];

  logic          f_we, f_re, p_we, p_re, g_we, g_re;
  logic [AW-1:0] f_wa, f_ra;
  logic [PAW-1:0] p_wa, p_ra;
  span_t         f_wd, p_wd;
  page_t         g_wd;

  logic [PW:0]   endp, room, a_end, s_end;
  page_t         extra, lclip, nl_tk, nl_gr;
  logic [CW-1:0] e_idx, im1, ip1, kp1, km1;
  logic          re;

  assign extra = req_q - cur_q;
  assign endp  = {1'b0, gp_q} + {1'b0, cur_q};
  assign room  = (PW+1)'(NPAGES) - {1'b0, pr_q.s};
  assign lclip = ({1'b0, pr_q.l} > room) ? room[PW-1:0] : pr_q.l;
  assign a_end = {1'b0, a_q.s} + {1'b0, a_q.l};
  assign s_end = {1'b0, s_q} + {1'b0, l_q};
  assign im1   = i_q - CW'(1);
  assign ip1   = i_q + CW'(1);
  assign kp1   = k_q + CW'(1);
  assign km1   = k_q - CW'(1);
  assign e_idx = top_q ? im1 : i_q;
  assign nl_tk = fr_q.l - req_q;
  assign nl_gr = fr_q.l - extra;
  assign re    = (op_q == OP_REALLOC) && (gp_q != '0);

  always_comb begin
    stat_o.init      = init_q;
    stat_o.op        = op_q;
    stat_o.gp_zero   = (gp_q == '0);
    stat_o.req_zero  = (req_q == '0);
    stat_o.top       = top_q;
    stat_o.pend_full = (pcnt_q >= PCW'(NPEND));
    stat_o.free_full = (fcnt_q >= CW'(NREG));
    stat_o.tk_end    = top_q ? (i_q == '0) : (i_q >= fcnt_q);
    stat_o.fit       = (fr_q.l >= req_q);
    stat_o.tk_zero   = (fr_q.l == req_q);
    stat_o.keep      = (req_q <= gl_q);
    stat_o.gr_fit    = ({1'b0, fr_q.s} == endp) && (fr_q.l >= extra);
    stat_o.gr_zero   = (fr_q.l == extra);
    stat_o.dr_more   = (kp1 < fcnt_q);
    stat_o.ra_end    = (j_q >= pcnt_q);
    stat_o.ra_skip   = (pr_q.s == '0) || (lclip == '0);
    stat_o.i_end     = (i_q >= fcnt_q);
    stat_o.rs_brk    = (s_q < fr_q.s);
    stat_o.c1        = (i_q != '0) && (a_end == {1'b0, s_q});
    stat_o.c2        = (i_q < fcnt_q) && (s_end == {1'b0, fr_q.s});
    stat_o.ins_more  = (k_q > i_q);
    stat_o.jn_small  = (fcnt_q < CW'(2));
    stat_o.jn_end    = (ip1 >= fcnt_q);
    stat_o.jn_adj    = (a_end == {1'b0, fr_q.s});
  end

  always_comb begin
    f_we = 1'b0;
    f_re = 1'b0;
    f_wa = i_q[AW-1:0];
    f_ra = i_q[AW-1:0];
    f_wd = fr_q;
    p_we = 1'b0;
    p_re = 1'b0;
    p_wa = pcnt_q[PAW-1:0];
    p_ra = j_q[PAW-1:0];
    p_wd = pr_q;
    g_we = 1'b0;
    g_re = 1'b0;
    g_wd = req_q;
    case (cmd_i)
      DP_INIT: begin
        f_we = 1'b1;
        f_wa = '0;
        f_wd = '{s: PW'(1), l: tot_q - PW'(1)};
      end
      DP_G_RD: g_re = 1'b1;
      DP_FR_PUSH: begin
        p_we = 1'b1;
        p_wd = '{s: gp_q, l: gl_q};
      end
      DP_RD_I: f_re = 1'b1;
      DP_RD_IM1: begin
        f_re = 1'b1;
        f_ra = im1[AW-1:0];
      end
      DP_RD_I1: begin
        f_re = 1'b1;
        f_ra = ip1[AW-1:0];
      end
      DP_RD_K1: begin
        f_re = 1'b1;
        f_ra = kp1[AW-1:0];
      end
      DP_RD_KM1: begin
        f_re = 1'b1;
        f_ra = km1[AW-1:0];
      end
      DP_JN_INIT: begin
        f_re = 1'b1;
        f_ra = '0;
      end
      DP_TK_TAKE: begin
        f_we = (nl_tk != '0);
        f_wa = e_idx[AW-1:0];
        f_wd = top_q ? span_t'{s: fr_q.s, l: nl_tk}
                     : span_t'{s: fr_q.s + req_q, l: nl_tk};
      end
      DP_GR_TAKE: begin
        f_we = (nl_gr != '0);
        f_wd = '{s: fr_q.s + extra, l: nl_gr};
        g_we = 1'b1;
      end
      DP_DR_WR: begin
        f_we = 1'b1;
        f_wa = k_q[AW-1:0];
      end
      DP_AL_OK: begin
        g_we = 1'b1;
        p_we = re;
        p_wd = '{s: gp_q, l: cur_q};
      end
      DP_RA_RD: p_re = 1'b1;
      DP_RA_KEEP: begin
        p_we = 1'b1;
        p_wa = kept_q[PAW-1:0];
      end
      DP_RS_M1: begin
        f_we = 1'b1;
        f_wa = im1[AW-1:0];
        f_wd = '{s: a_q.s, l: a_q.l + l_q};
      end
      DP_RS_M2: begin
        f_we = 1'b1;
        f_wd = '{s: s_q, l: fr_q.l + l_q};
      end
      DP_INS_WR: begin
        f_we = 1'b1;
        f_wa = k_q[AW-1:0];
      end
      DP_INS_PUT: begin
        f_we = 1'b1;
        f_wd = '{s: s_q, l: l_q};
      end
      DP_JN_MRG: begin
        f_we = 1'b1;
        f_wd = '{s: a_q.s, l: a_q.l + fr_q.l};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fmem[f_wa] <= f_wd;
    end
    if (f_re) begin
      fr_q <= fmem[f_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    if (p_re) begin
      pr_q <= pmem[p_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[(cmd_i == DP_GR_TAKE) ? gp_q : res_q] <= g_wd;
    end
    if (g_re) begin
      gl_q <= gmem[gp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= PW'(160);
      init_q <= 1'b1;
      fcnt_q <= CW'(1);
      pcnt_q <= '0;
      i_q    <= '0;
      k_q    <= '0;
      j_q    <= '0;
      kept_q <= '0;
    end else if (cfg_we_i) begin
      tot_q  <= cfg_wdata_i;
      init_q <= 1'b1;
      fcnt_q <= (cfg_wdata_i >= PW'(2)) ? CW'(1) : '0;
      pcnt_q <= '0;
    end else begin
      case (cmd_i)
        DP_INIT:     init_q <= 1'b0;
        DP_FR_PUSH:  pcnt_q <= pcnt_q + PCW'(1);
        DP_AL_OK:    if (re) pcnt_q <= pcnt_q + PCW'(1);
        DP_DR_WR:    k_q <= kp1;
        DP_DR_END:   fcnt_q <= fcnt_q - CW'(1);
        DP_I_INC:    i_q <= ip1;
        DP_RE_GROW:  i_q <= '0;
        DP_TK_INIT:  i_q <= top_q ? fcnt_q : '0;
        DP_TK_STEP:  i_q <= top_q ? im1 : ip1;
        DP_TK_TAKE:  k_q <= e_idx;
        DP_GR_TAKE:  k_q <= i_q;
        DP_RA_INIT: begin
          j_q    <= '0;
          kept_q <= '0;
        end
        DP_RA_LD:    i_q <= '0;
        DP_RA_NEXT:  j_q <= j_q + PCW'(1);
        DP_RA_KEEP: begin
          kept_q <= kept_q + PCW'(1);
          j_q    <= j_q + PCW'(1);
        end
        DP_RA_END:   pcnt_q <= kept_q;
        DP_RS_STEP:  i_q <= ip1;
        DP_INS_INIT: k_q <= fcnt_q;
        DP_INS_WR:   k_q <= km1;
        DP_INS_PUT:  fcnt_q <= fcnt_q + CW'(1);
        DP_JN_INIT:  i_q <= '0;
        DP_JN_MRG:   k_q <= ip1;
        DP_JN_ADV:   i_q <= ip1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      DP_LATCH: begin
        op_q  <= op_i;
        req_q <= request_pages_i;
        top_q <= from_top_i;
        gp_q  <= grant_page_i;
        res_q <= '0;
        st_q  <= ST_OK;
        mv_q  <= 1'b0;
      end
      DP_SET_ST1: st_q <= ST_NOSPACE;
      DP_SET_ST2: st_q <= ST_FULL;
      DP_RE_KEEP: res_q <= gp_q;
      DP_RE_GROW: cur_q <= gl_q;
      DP_TK_TAKE: res_q <= top_q ? fr_q.s + nl_tk : fr_q.s;
      DP_GR_TAKE: res_q <= gp_q;
      DP_AL_OK: begin
        st_q <= ST_OK;
        if (re) mv_q <= 1'b1;
      end
      DP_AL_FAIL: begin
        res_q <= '0;
        st_q  <= (pcnt_q != '0) ? ST_FULL : ST_NOSPACE;
      end
      DP_RA_LD: begin
        s_q <= pr_q.s;
        l_q <= lclip;
      end
      DP_RS_STEP: a_q <= fr_q;
      DP_JN_LDA:  a_q <= fr_q;
      DP_JN_ADV:  a_q <= fr_q;
      DP_JN_MRG:  a_q.l <= a_q.l + fr_q.l;
      DP_OUT: begin
        out_res_q <= res_q;
        out_st_q  <= st_q;
        out_mv_q  <= mv_q;
      end
      default: begin
      end
    endcase
  end

  assign result_page_o = out_res_q;
  assign status_o      = out_st_q;
  assign moved_o       = out_mv_q;

`ifndef ASSERT_OFF
  a_fcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CW'(NREG)) else $error("region count beyond table size");
  a_pcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= PCW'(NPEND)) else $error("pending count beyond table size");
  a_kept_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= j_q) else $error("kept entries overtake merge index");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == DP_INS_PUT |-> fcnt_q < CW'(NREG)) else $error("insert into full table");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == DP_AL_OK && re) |-> pcnt_q < PCW'(NPEND))
    else $error("pending push into full table");
`endif

endmodule

// ===== hdl/prla_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page region allocator controller
// Sequences scans, merges, shifts and result hand-off through datapath commands.
// ----------------------------------------------------------------------------
module prla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  input  prla_pkg::dp_stat_t stat_i,
  output prla_pkg::dp_cmd_e  cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);
  import prla_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_FREE, S_RE_CHK, S_GR_CHK, S_GR_EV, S_GR_MISS,
    S_AL_START, S_TK_START, S_TK_CHK, S_TK_EV, S_TK_HIT, S_TK_MISS,
    S_DR_CHK, S_DR_WR, S_RA_CHK, S_RA_EV, S_RA_DONE, S_RS_CHK, S_RS_EV,
    S_RS_DEC, S_INS_CHK, S_INS_WR, S_JN_START, S_JN_LD, S_JN_CHK, S_JN_EV,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {R_TAKE, R_GROW, R_JOIN} dret_e;
  typedef enum logic {R_ALLOC, R_RE} rret_e;

  state_e state_q, state_d;
  dret_e  dret_q, dret_d;
  rret_e  rret_q, rret_d;
  logic   phase_q, phase_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    dret_d   = dret_q;
    rret_d   = rret_q;
    phase_d  = phase_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (stat_i.init) begin
          cmd_o = DP_INIT;
        end else if (in_valid_i) begin
          cmd_o   = DP_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          OP_ALLOC: state_d = S_AL_START;
          OP_FREE: begin
            if (stat_i.gp_zero) begin
              state_d = S_FIN;
            end else begin
              cmd_o   = DP_G_RD;
              state_d = S_FREE;
            end
          end
          OP_REALLOC: begin
            if (stat_i.gp_zero) begin
              state_d = S_AL_START;
            end else begin
              cmd_o   = DP_G_RD;
              state_d = S_RE_CHK;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_FREE: begin
        cmd_o   = stat_i.pend_full ? DP_SET_ST2 : DP_FR_PUSH;
        state_d = S_FIN;
      end
      S_RE_CHK: begin
        if (stat_i.keep) begin
          cmd_o   = DP_RE_KEEP;
          state_d = S_FIN;
        end else begin
          cmd_o   = DP_RE_GROW;
          state_d = S_GR_CHK;
        end
      end
      S_GR_CHK: begin
        if (stat_i.i_end) begin
          state_d = S_GR_MISS;
        end else begin
          cmd_o   = DP_RD_I;
          state_d = S_GR_EV;
        end
      end
      S_GR_EV: begin
        if (stat_i.gr_fit) begin
          cmd_o = DP_GR_TAKE;
          if (stat_i.gr_zero) begin
            dret_d  = R_GROW;
            state_d = S_DR_CHK;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          cmd_o   = DP_I_INC;
          state_d = S_GR_CHK;
        end
      end
      S_GR_MISS: begin
        if (stat_i.pend_full) begin
          cmd_o   = DP_RA_INIT;
          rret_d  = R_RE;
          state_d = S_RA_CHK;
        end else begin
          state_d = S_AL_START;
        end
      end
      S_AL_START: begin
        if (stat_i.req_zero) begin
          cmd_o   = DP_SET_ST1;
          state_d = S_FIN;
        end else begin
          phase_d = 1'b0;
          cmd_o   = DP_TK_INIT;
          state_d = S_TK_CHK;
        end
      end
      S_TK_START: begin
        cmd_o   = DP_TK_INIT;
        state_d = S_TK_CHK;
      end
      S_TK_CHK: begin
        if (stat_i.tk_end) begin
          state_d = S_TK_MISS;
        end else begin
          cmd_o   = stat_i.top ? DP_RD_IM1 : DP_RD_I;
          state_d = S_TK_EV;
        end
      end
      S_TK_EV: begin
        if (stat_i.fit) begin
          cmd_o = DP_TK_TAKE;
          if (stat_i.tk_zero) begin
            dret_d  = R_TAKE;
            state_d = S_DR_CHK;
          end else begin
            state_d = S_TK_HIT;
          end
        end else begin
          cmd_o   = DP_TK_STEP;
          state_d = S_TK_CHK;
        end
      end
      S_TK_HIT: begin
        cmd_o   = DP_AL_OK;
        state_d = S_FIN;
      end
      S_TK_MISS: begin
        if (phase_q) begin
          cmd_o   = DP_AL_FAIL;
          state_d = S_FIN;
        end else begin
          phase_d = 1'b1;
          cmd_o   = DP_RA_INIT;
          rret_d  = R_ALLOC;
          state_d = S_RA_CHK;
        end
      end
      S_DR_CHK: begin
        if (stat_i.dr_more) begin
          cmd_o   = DP_RD_K1;
          state_d = S_DR_WR;
        end else begin
          cmd_o = DP_DR_END;
          case (dret_q)
            R_TAKE:  state_d = S_TK_HIT;
            R_GROW:  state_d = S_FIN;
            default: state_d = S_JN_CHK;
          endcase
        end
      end
      S_DR_WR: begin
        cmd_o   = DP_DR_WR;
        state_d = S_DR_CHK;
      end
      S_RA_CHK: begin
        if (stat_i.ra_end) begin
          cmd_o   = DP_RA_END;
          state_d = (rret_q == R_ALLOC) ? S_TK_START : S_RA_DONE;
        end else begin
          cmd_o   = DP_RA_RD;
          state_d = S_RA_EV;
        end
      end
      S_RA_EV: begin
        if (stat_i.ra_skip) begin
          cmd_o   = DP_RA_NEXT;
          state_d = S_RA_CHK;
        end else begin
          cmd_o   = DP_RA_LD;
          state_d = S_RS_CHK;
        end
      end
      S_RA_DONE: begin
        if (stat_i.pend_full) begin
          cmd_o   = DP_SET_ST2;
          state_d = S_FIN;
        end else begin
          state_d = S_AL_START;
        end
      end
      S_RS_CHK: begin
        if (stat_i.i_end) begin
          state_d = S_RS_DEC;
        end else begin
          cmd_o   = DP_RD_I;
          state_d = S_RS_EV;
        end
      end
      S_RS_EV: begin
        if (stat_i.rs_brk) begin
          state_d = S_RS_DEC;
        end else begin
          cmd_o   = DP_RS_STEP;
          state_d = S_RS_CHK;
        end
      end
      S_RS_DEC: begin
        if (stat_i.c1) begin
          cmd_o   = DP_RS_M1;
          state_d = S_JN_START;
        end else if (stat_i.c2) begin
          cmd_o   = DP_RS_M2;
          state_d = S_JN_START;
        end else if (stat_i.free_full) begin
          cmd_o   = DP_RA_KEEP;
          state_d = S_RA_CHK;
        end else begin
          cmd_o   = DP_INS_INIT;
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat_i.ins_more) begin
          cmd_o   = DP_RD_KM1;
          state_d = S_INS_WR;
        end else begin
          cmd_o   = DP_INS_PUT;
          state_d = S_JN_START;
        end
      end
      S_INS_WR: begin
        cmd_o   = DP_INS_WR;
        state_d = S_INS_CHK;
      end
      S_JN_START: begin
        if (stat_i.jn_small) begin
          cmd_o   = DP_RA_NEXT;
          state_d = S_RA_CHK;
        end else begin
          cmd_o   = DP_JN_INIT;
          state_d = S_JN_LD;
        end
      end
      S_JN_LD: begin
        cmd_o   = DP_JN_LDA;
        state_d = S_JN_CHK;
      end
      S_JN_CHK: begin
        if (stat_i.jn_end) begin
          cmd_o   = DP_RA_NEXT;
          state_d = S_RA_CHK;
        end else begin
          cmd_o   = DP_RD_I1;
          state_d = S_JN_EV;
        end
      end
      S_JN_EV: begin
        if (stat_i.jn_adj) begin
          cmd_o   = DP_JN_MRG;
          dret_d  = R_JOIN;
          state_d = S_DR_CHK;
        end else begin
          cmd_o   = DP_JN_ADV;
          state_d = S_JN_CHK;
        end
      end
      S_FIN: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o    = DP_OUT;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dret_q   <= R_TAKE;
      rret_q   <= R_ALLOC;
      phase_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dret_q   <= dret_d;
      rret_q   <= rret_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || stat_i.init;
  assign out_valid_o = ovalid_q;

endmodule

// ===== hdl/page_region_allocator.sv =====
// Sequence: a free or a reallocate that keeps or grows its grant in place registers
// its result after a grant length read, plus a scan of region entries for a grow;
// an allocate scans region entries for a first fit. A miss adds a merge of every
// pending free (each compared with and shifted into the region table) and a rescan.
// Throughput: one item at a time; input is taken again once the result is registered.
// Reset: one region covering pages 1..159, no pending frees; after reset or a pool
// size write the region table is rewritten before input is taken, and input stalls.
// ----------------------------------------------------------------------------
// Page region allocator
// First-fit page allocator with deferred frees and coalescing on demand.
// ----------------------------------------------------------------------------
module page_region_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  prla_pkg::page_t cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      op_i,
  input  prla_pkg::page_t request_pages_i,
  input  logic            from_top_i,
  input  prla_pkg::page_t grant_page_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output prla_pkg::page_t result_page_o,
  output logic [1:0]      status_o,
  output logic            moved_o
);
  import prla_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;

  prla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  prla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .request_pages_i (request_pages_i),
    .from_top_i      (from_top_i),
    .grant_page_i    (grant_page_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_page_o   (result_page_o),
    .status_o        (status_o),
    .moved_o         (moved_o)
  );

endmodule

// ===== tb/tb_page_region_allocator.sv =====
// ----------------------------------------------------------------------------
// Page region allocator testbench
// Drives allocate, free, reallocate and spare-code items against an in-bench
// predictor of the free table, pending frees and grant lengths, under several
// pool sizes, idle patterns and output stalls, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_page_region_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import prla_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    page_t      page;
    logic [1:0] st;
    logic       mv;
  } outcome_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  page_t           cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      op_i = OP_ALLOC;
  page_t           request_pages_i = '0;
  logic            from_top_i = 1'b0;
  page_t           grant_page_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  page_t           result_page_o;
  logic [1:0]      status_o;
  logic            moved_o;

  page_region_allocator i_dut (.*);

  always #5ns clk_i = ~clk_i;

  int unsigned pool_size;
  int unsigned reg_start[NREG];
  int unsigned reg_len[NREG];
  int unsigned reg_cnt;
  int unsigned pend_start[NPEND];
  int unsigned pend_len[NPEND];
  int unsigned pend_cnt;
  int unsigned grant_len[NPAGES];
  page_t       live_grants[$];
  outcome_t    awaited[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0;

  function automatic void pool_reinit();
    reg_cnt = 0;
    pend_cnt = 0;
    if (pool_size >= 2) begin
      reg_start[0] = 1;
      reg_len[0] = (pool_size - 1 > NPAGES - 1) ? NPAGES - 1 : pool_size - 1;
      reg_cnt = 1;
    end
  endfunction

  function automatic void region_drop(int unsigned i);
    for (int unsigned k = i; k + 1 < reg_cnt; k++) begin
      reg_start[k] = reg_start[k+1];
      reg_len[k] = reg_len[k+1];
    end
    reg_cnt--;
  endfunction

  function automatic void region_join();
    int unsigned i;
    i = 0;
    while (i + 1 < reg_cnt) begin
      if (reg_start[i] + reg_len[i] == reg_start[i+1]) begin
        reg_len[i] += reg_len[i+1];
        region_drop(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic int unsigned carve(int unsigned req, bit top);
    int unsigned r;
    int unsigned k;
    if (!top) begin
      for (int unsigned i = 0; i < reg_cnt; i++) begin
        if (reg_len[i] >= req) begin
          r = reg_start[i];
          reg_start[i] += req;
          reg_len[i] -= req;
          if (reg_len[i] == 0) region_drop(i);
          return r;
        end
      end
    end else begin
      for (int unsigned i = reg_cnt; i > 0; i--) begin
        k = i - 1;
        if (reg_len[k] >= req) begin
          r = reg_start[k] + reg_len[k] - req;
          reg_len[k] -= req;
          if (reg_len[k] == 0) region_drop(k);
          return r;
        end
      end
    end
    return 0;
  endfunction

  function automatic bit give_back(int unsigned s, int unsigned l);
    int unsigned i;
    if (s == 0 || s >= NPAGES) return 1'b1;
    if (l > NPAGES - s) l = NPAGES - s;
    if (l == 0) return 1'b1;
    for (i = 0; i < reg_cnt; i++) if (s < reg_start[i]) break;
    if (i > 0 && reg_start[i-1] + reg_len[i-1] == s) begin
      reg_len[i-1] += l;
      region_join();
      return 1'b1;
    end
    if (i < reg_cnt && s + l == reg_start[i]) begin
      reg_start[i] = s;
      reg_len[i] += l;
      region_join();
      return 1'b1;
    end
    if (reg_cnt >= NREG) return 1'b0;
    for (int unsigned k = reg_cnt; k > i; k--) begin
      reg_start[k] = reg_start[k-1];
      reg_len[k] = reg_len[k-1];
    end
    reg_start[i] = s;
    reg_len[i] = l;
    reg_cnt++;
    region_join();
    return 1'b1;
  endfunction

  function automatic void merge_pending();
    int unsigned kept;
    kept = 0;
    for (int unsigned j = 0; j < pend_cnt; j++) begin
      if (!give_back(pend_start[j], pend_len[j])) begin
        pend_start[kept] = pend_start[j];
        pend_len[kept] = pend_len[j];
        kept++;
      end
    end
    pend_cnt = kept;
  endfunction

  function automatic int unsigned grab(int unsigned req, bit top, ref logic [1:0] st);
    int unsigned p;
    if (req == 0) begin
      st = ST_NOSPACE;
      return 0;
    end
    p = carve(req, top);
    if (p == 0) begin
      merge_pending();
      p = carve(req, top);
    end
    if (p == 0 || p >= NPAGES) begin
      st = pend_cnt ? ST_FULL : ST_NOSPACE;
      return 0;
    end
    grant_len[p] = req;
    st = ST_OK;
    return p;
  endfunction

  function automatic bit grow_at(int unsigned first, int unsigned stop,
                                 int unsigned extra, int unsigned newlen);
    for (int unsigned i = 0; i < reg_cnt; i++) begin
      if (reg_start[i] == stop && reg_len[i] >= extra) begin
        reg_start[i] += extra;
        reg_len[i] -= extra;
        if (reg_len[i] == 0) region_drop(i);
        grant_len[first] = newlen;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void forget_grant(int unsigned gp);
    foreach (live_grants[i]) begin
      if (live_grants[i] == gp) begin
        live_grants.delete(i);
        return;
      end
    end
  endfunction

  function automatic outcome_t predict_request(logic [1:0] op, int unsigned req, bit top,
                                               int unsigned gp);
    outcome_t o;
    int unsigned cur;
    logic [1:0] st;
    int unsigned res;
    o = '{page: '0, st: ST_OK, mv: 1'b0};
    st = ST_OK;
    res = 0;
    if (op == OP_ALLOC || (op == OP_REALLOC && gp == 0)) begin
      res = grab(req, top, st);
      if (res != 0) live_grants.push_back(page_t'(res));
    end else if (op == OP_FREE) begin
      if (gp != 0) begin
        if (pend_cnt >= NPEND) begin
          st = ST_FULL;
        end else begin
          pend_start[pend_cnt] = gp;
          pend_len[pend_cnt] = grant_len[gp];
          pend_cnt++;
          forget_grant(gp);
        end
      end
    end else if (op == OP_REALLOC) begin
      cur = grant_len[gp];
      if (req <= cur) begin
        res = gp;
      end else if (grow_at(gp, gp + cur, req - cur, req)) begin
        res = gp;
      end else begin
        if (pend_cnt >= NPEND) merge_pending();
        if (pend_cnt >= NPEND) begin
          st = ST_FULL;
        end else begin
          res = grab(req, top, st);
          if (res != 0) begin
            pend_start[pend_cnt] = gp;
            pend_len[pend_cnt] = cur;
            pend_cnt++;
            o.mv = 1'b1;
            forget_grant(gp);
            live_grants.push_back(page_t'(res));
          end
        end
      end
    end
    o.page = page_t'(res);
    o.st = st;
    return o;
  endfunction

  task automatic send_item(logic [1:0] op, int unsigned req, int unsigned top,
                           int unsigned gp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    request_pages_i = page_t'(req);
    from_top_i = top[0];
    grant_page_i = page_t'(gp);
    do @(posedge clk_i); while (in_stall_o);
    awaited.push_back(predict_request(op, req, top[0], gp));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (awaited.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_pool(int unsigned pages);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = page_t'(pages);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pool_size = pages;
    pool_reinit();
    live_grants.delete();
  endtask

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(64, 1);
    if (r < 98) return $urandom_range(NPAGES - 1, 0);
    return NPAGES - 1;
  endfunction

  always begin
    @(negedge clk_i);
    if (hold_cycles != 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = stall_pct != 0 && $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: page %0d status %0d moved %0b",
                   result_page_o, status_o, moved_o);
      end else begin
        want = awaited.pop_front();
        if (result_page_o !== want.page || status_o !== want.st || moved_o !== want.mv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected page %0d status %0d moved %0b, got %0d %0d %0b",
                     want.page, want.st, want.mv, result_page_o, status_o, moved_o);
        end
      end
    end
  end

  task automatic test_directed();
    page_t a;
    page_t b;
    send_item(OP_ALLOC, 1, 0, 0);
    a = live_grants[$];
    send_item(OP_ALLOC, 4, 1, 0);
    b = live_grants[$];
    send_item(OP_ALLOC, NPAGES - 1, 0, 0);
    send_item(OP_ALLOC, NPAGES - 1, 1, 0);
    send_item(OP_ALLOC, 0, 0, 0);
    send_item(OP_SPARE, 7, 1, a);
    send_item(OP_REALLOC, 1, 0, a);
    send_item(OP_REALLOC, 0, 0, b);
    send_item(OP_REALLOC, 3, 0, b);
    send_item(OP_REALLOC, 5, 0, a);
    send_item(OP_REALLOC, 6, 1, 0);
    send_item(OP_FREE, 0, 0, 0);
    send_item(OP_FREE, 1, 1, live_grants[0]);
    send_item(OP_ALLOC, 150, 0, 0);
    send_item(OP_ALLOC, 2, 1, 0);
    send_item(OP_FREE, 0, 0, live_grants[0]);
    send_item(OP_ALLOC, 159, 0, 0);
    send_item(OP_ALLOC, 1, 0, 0);
  endtask

  task automatic test_tables_full();
    set_pool(NPAGES - 1);
    repeat (140) send_item(OP_ALLOC, 1, 0, 0);
    for (int unsigned p = 2; p <= 140; p += 2) send_item(OP_FREE, 0, 0, p);
    send_item(OP_REALLOC, 9, 0, 3);
    send_item(OP_ALLOC, NPAGES - 1, 1, 0);
    send_item(OP_ALLOC, 4000, 0, 0);
    send_item(OP_REALLOC, 2, 1, 5);
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    repeat (12) send_item(OP_ALLOC, $urandom_range(4, 1), $urandom_range(1), 0);
    drain();
  endtask

  task automatic test_random(int unsigned items, int unsigned pool, int unsigned sidle,
                             int unsigned stall);
    int unsigned r;
    int unsigned idx;
    set_pool(pool);
    send_idle_pct = sidle;
    stall_pct = stall;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 100 == 50) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end else if (n % 100 == 70) begin
        send_idle_pct = sidle;
        stall_pct = stall;
      end
      r = $urandom_range(99);
      if (r < 45 || live_grants.size() == 0) begin
        send_item(OP_ALLOC, pick_size(), $urandom_range(1), 0);
      end else if (r < 78) begin
        idx = $urandom_range(live_grants.size() - 1);
        send_item(OP_FREE, pick_size(), $urandom_range(1), live_grants[idx]);
      end else if (r < 94) begin
        idx = $urandom_range(live_grants.size() - 1);
        send_item(OP_REALLOC, pick_size(), $urandom_range(1), live_grants[idx]);
      end else if (r < 97) begin
        send_item(OP_REALLOC, pick_size(), $urandom_range(1), 0);
      end else begin
        send_item(OP_SPARE, $urandom_range(NPAGES - 1), $urandom_range(1),
                  $urandom_range(NPAGES - 1));
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    pool_size = 160;
    pool_reinit();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_tables_full();
    test_backpressure();
    test_random(350, 160, 0, 0);
    test_random(350, 32, 77, 0);
    test_random(350, NPAGES - 1, 0, 77);
    test_random(350, $urandom_range(NPAGES - 1, 32), 10, 10);
    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
